>>> hw/rtl/orl_pkg.sv
// shared constants, codes and interface types of the ring log
package orl_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned REC_W = CHAN_W + TIME_W + VAL_W;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_NEWEST = 2'd1;
  localparam logic [1:0] MODE_BACK   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_LAST  = 2'd2;

  typedef struct packed {
    logic accept;
    logic capture;
  } orl_cmd_t;

  typedef struct packed {
    logic is_read;
  } orl_stat_t;

endpackage

>>> hw/rtl/orl_ram.sv
// generic single-port-write, single-port-read ram with registered read
module orl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/orl_ctrl.sv
// controller state machine sequencing one transfer at a time
module orl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  orl_pkg::orl_stat_t stat,
  output orl_pkg::orl_cmd_t  cmd
);
  import orl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_HOLD
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept  = (state == S_IDLE) && in_valid;
    cmd.capture = (state == S_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_stall <= 1'b1;
            if (stat.is_read) begin
              state <= S_READ;
            end else begin
              state     <= S_HOLD;
              out_valid <= 1'b1;
            end
          end
        end
        S_READ: begin
          state     <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: begin
          if (!out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_stall  <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          in_stall  <= 1'b0;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/orl_dp.sv
// datapath: pointers, record store, valid bits and result registers
module orl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  orl_pkg::orl_cmd_t           cmd,
  output orl_pkg::orl_stat_t          stat,
  input  logic [1:0]                  mode,
  input  logic [orl_pkg::CHAN_W-1:0]  channel_code,
  input  logic [orl_pkg::TIME_W-1:0]  timestamp,
  input  logic [orl_pkg::VAL_W-1:0]   value_bits,
  output logic [1:0]                  status,
  output logic [orl_pkg::CHAN_W-1:0]  read_channel,
  output logic [orl_pkg::TIME_W-1:0]  read_timestamp,
  output logic [orl_pkg::VAL_W-1:0]   read_value
);
  import orl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] cursor;
  logic [DEPTH-1:0] valid;
  logic             rd_vld;

  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] tail_inc;
  logic [IDX_W-1:0] cursor_dec;
  logic             empty;
  logic             wr_en;
  logic [REC_W-1:0] rd_data;

  assign head_inc   = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec   = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc   = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign cursor_dec = (cursor == '0) ? LAST_IDX : cursor - 1'b1;
  assign empty      = (head == tail);
  assign wr_en      = cmd.accept && (mode == MODE_APPEND);

  assign stat.is_read = (mode == MODE_READ);

  orl_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(head),
    .wr_data({channel_code, timestamp, value_bits}),
    .rd_addr(cursor),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      cursor <= '0;
      valid  <= '0;
    end else if (cmd.accept) begin
      case (mode)
        MODE_APPEND: begin
          valid[head] <= 1'b1;
          head        <= head_inc;
          if (head_inc == tail) begin
            tail <= tail_inc;
          end
        end
        MODE_NEWEST: begin
          if (!empty) begin
            cursor <= head_dec;
          end
        end
        MODE_BACK: begin
          cursor <= cursor_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_vld         <= valid[cursor];
      read_channel   <= '0;
      read_timestamp <= '0;
      read_value     <= '0;
      case (mode)
        MODE_APPEND: status <= ST_OK;
        MODE_NEWEST: status <= empty ? ST_EMPTY : ST_OK;
        MODE_BACK:   status <= (cursor_dec == tail) ? ST_LAST : ST_OK;
        default: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else if (cursor == tail) begin
            status <= ST_LAST;
          end else begin
            status <= ST_OK;
          end
        end
      endcase
    end else if (cmd.capture && rd_vld) begin
      read_channel   <= rd_data[REC_W-1 -: CHAN_W];
      read_timestamp <= rd_data[VAL_W +: TIME_W];
      read_value     <= rd_data[VAL_W-1:0];
    end
  end

endmodule

>>> hw/rtl/overwriting_ring_log_with_cursor_unit.sv
// top level of the overwriting ring log with browse cursor
//
//  channel  handshake             payload
//  in       in_valid / in_stall   mode, channel_code, timestamp, value_bits
//  out      out_valid / out_stall status, read_channel, read_timestamp, read_value
//
// append, cursor moves: result registered on acceptance; read: passes through S_READ (registered ram read)
// one item in flight; next transfer taken in the cycle after the result is taken,
// so a new item is not accepted before the previous result has left
// rst clears pointers and the per-record valid bits together, no sweep
// out_stall holds the result register and keeps in_stall high
module overwriting_ring_log_with_cursor_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [orl_pkg::CHAN_W-1:0]  channel_code,
  input  logic [orl_pkg::TIME_W-1:0]  timestamp,
  input  logic [orl_pkg::VAL_W-1:0]   value_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [orl_pkg::CHAN_W-1:0]  read_channel,
  output logic [orl_pkg::TIME_W-1:0]  read_timestamp,
  output logic [orl_pkg::VAL_W-1:0]   read_value
);
  import orl_pkg::*;

  orl_cmd_t  cmd;
  orl_stat_t stat;

  orl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  orl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .channel_code  (channel_code),
    .timestamp     (timestamp),
    .value_bits    (value_bits),
    .status        (status),
    .read_channel  (read_channel),
    .read_timestamp(read_timestamp),
    .read_value    (read_value)
  );

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the overwriting ring log with browse cursor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import orl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]        status;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] ts;
    logic [VAL_W-1:0]  val;
  } log_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        mode = MODE_APPEND;
  logic [CHAN_W-1:0] channel_code = '0;
  logic [TIME_W-1:0] timestamp = '0;
  logic [VAL_W-1:0]  value_bits = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [CHAN_W-1:0] read_channel;
  logic [TIME_W-1:0] read_timestamp;
  logic [VAL_W-1:0]  read_value;

  // shadow copy of the log
  logic [CHAN_W-1:0] ring_chan [DEPTH] = '{default: '0};
  logic [TIME_W-1:0] ring_ts [DEPTH] = '{default: '0};
  logic [VAL_W-1:0]  ring_val [DEPTH] = '{default: '0};
  logic [IDX_W-1:0]  ring_head = '0;
  logic [IDX_W-1:0]  ring_tail = '0;
  logic [IDX_W-1:0]  ring_cursor = '0;

  log_reply_t log_replies_q [$];

  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_reads = 0;
  int unsigned n_last = 0;
  int unsigned n_empty = 0;
  int unsigned n_fail = 0;
  int unsigned cycles = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  overwriting_ring_log_with_cursor_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .channel_code   (channel_code),
    .timestamp      (timestamp),
    .value_bits     (value_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .read_channel   (read_channel),
    .read_timestamp (read_timestamp),
    .read_value     (read_value)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, log_replies_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic log_reply_t apply_log_op(logic [1:0] op, logic [CHAN_W-1:0] ch,
                                              logic [TIME_W-1:0] ts, logic [VAL_W-1:0] vb);
    log_reply_t r;
    r = '{status: ST_OK, chan: '0, ts: '0, val: '0};
    case (op)
      MODE_APPEND: begin
        ring_chan[ring_head] = ch;
        ring_ts[ring_head] = ts;
        ring_val[ring_head] = vb;
        ring_head = idx_next(ring_head);
        // full log drops its oldest record
        if (ring_head == ring_tail) ring_tail = idx_next(ring_tail);
      end
      MODE_NEWEST: begin
        if (ring_head == ring_tail) r.status = ST_EMPTY;
        else ring_cursor = idx_prev(ring_head);
      end
      MODE_BACK: begin
        ring_cursor = idx_prev(ring_cursor);
        if (ring_cursor == ring_tail) r.status = ST_LAST;
      end
      default: begin
        r.chan = ring_chan[ring_cursor];
        r.ts = ring_ts[ring_cursor];
        r.val = ring_val[ring_cursor];
        if (ring_head == ring_tail) r.status = ST_EMPTY;
        else if (ring_cursor == ring_tail) r.status = ST_LAST;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // handshakes are stable between edges, so both channels are sampled at negedge
  always @(negedge clk) begin
    log_reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (log_replies_q.size() == 0) begin
          $error("result transfer with nothing expected: status %0h", status);
          n_fail++;
        end else begin
          want = log_replies_q.pop_front();
          check_field("status", want.status, status);
          check_field("read_channel", want.chan, read_channel);
          check_field("read_timestamp", want.ts, read_timestamp);
          check_field("read_value", want.val, read_value);
          n_checked++;
          if (want.status == ST_LAST) n_last++;
          if (want.status == ST_EMPTY) n_empty++;
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_READ) n_reads++;
        log_replies_q.push_back(apply_log_op(mode, channel_code, timestamp, value_bits));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  task automatic send_op(logic [1:0] op, logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] ts,
                         logic [VAL_W-1:0] vb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    channel_code <= ch;
    timestamp <= ts;
    value_bits <= vb;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    n_sent++;
  endtask

  task automatic do_op(logic [1:0] op);
    send_op(op, CHAN_W'(pick_word()), pick_word(), pick_word());
  endtask

  task automatic wait_log_idle();
    in_valid <= 1'b0;
    while (log_replies_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_log();
    do_op(MODE_NEWEST);
    do_op(MODE_READ);
    do_op(MODE_BACK);
    do_op(MODE_READ);
    do_op(MODE_NEWEST);
  endtask

  task automatic test_field_extremes();
    send_op(MODE_APPEND, '0, '0, '0);
    send_op(MODE_APPEND, '1, '1, '1);
    send_op(MODE_APPEND, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555);
    send_op(MODE_APPEND, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA);
    do_op(MODE_NEWEST);
    do_op(MODE_READ);
    repeat (3) begin
      do_op(MODE_BACK);
      do_op(MODE_READ);
    end
    // past the oldest record into never written entries
    do_op(MODE_BACK);
    do_op(MODE_READ);
  endtask

  task automatic test_stale_cursor();
    do_op(MODE_APPEND);
    do_op(MODE_APPEND);
    do_op(MODE_READ);
    do_op(MODE_NEWEST);
    do_op(MODE_READ);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (30) do_op(2'($urandom_range(0, 3)));
    no_idle = 1'b0;
  endtask

  task automatic test_random_sessions(int unsigned target);
    int n;
    while (n_sent < target) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
          repeat (n) do_op(MODE_APPEND);
        end
        4, 5, 6: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
          do_op(MODE_NEWEST);
          do_op(MODE_READ);
          repeat (n) begin
            do_op(MODE_BACK);
            if ($urandom_range(0, 3) != 0) do_op(MODE_READ);
          end
        end
        7: begin
          repeat ($urandom_range(1, 4)) do_op(MODE_APPEND);
          do_op(MODE_READ);
          do_op(MODE_BACK);
          do_op(MODE_READ);
        end
        default: repeat ($urandom_range(1, 8)) do_op(2'($urandom_range(0, 3)));
      endcase
    end
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_log_idle();
    do_op(MODE_NEWEST);
    do_op(MODE_READ);
    do_op(MODE_APPEND);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_log();
    test_field_extremes();
    test_stale_cursor();
    test_back_to_back();
    test_random_sessions(400);
    test_drain_pause();
    test_random_sessions(750);
    wait_log_idle();
    repeat (20) @(posedge clk);
    $display("sent %0d operations, checked %0d results (%0d reads)", n_sent, n_checked, n_reads);
    $display("oldest-record status seen %0d times, empty status %0d times", n_last, n_empty);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
